>>> sv/gbc_pkg.sv
`default_nettype none
package gbc_pkg;
   localparam int MaxSamples    = 4096;
   localparam int ExtraAttempts = 200;
   localparam int CntW  = 13;
   localparam int OffW  = 28;
   localparam int RawW  = 16;
   localparam int SumW  = 29;
   localparam int SqW   = 43;
   // widest values: the dividend |sum| * 655360, and the product n * sqsum
   localparam int DivW  = 64;

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_LOAD   = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_PASS   = 2'd1;
   localparam logic [1:0] ST_FAIL   = 2'd2;
   localparam logic [1:0] ST_BUSY   = 2'd3;

   localparam logic CSR_RANGE  = 1'b0;
   localparam logic CSR_TARGET = 1'b1;

   // scale in tenths of lsb per dps
   function automatic logic [10:0] scale_tenths(input logic [1:0] r);
      case (r)
         2'd0:    scale_tenths = 11'd1310;
         2'd1:    scale_tenths = 11'd655;
         2'd2:    scale_tenths = 11'd328;
         default: scale_tenths = 11'd164;
      endcase
   endfunction

   typedef struct packed {
      logic          start;
      logic [DivW-1:0] a;
      logic [DivW-1:0] b;
   } mul_req_type;
endpackage
`default_nettype wire

>>> sv/gbc_serial_mul.sv
`default_nettype none
// shift-add multiplier, one bit of b per cycle
module gbc_serial_mul import gbc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mul_req_type       req,
   output logic                   done,
   output logic [DivW-1:0]        prod
);
   logic [DivW-1:0] acc_ff, acc_in, a_ff, a_in, b_ff, b_in;
   logic            run_ff, run_in;

   always_comb begin
      acc_in = acc_ff; a_in = a_ff; b_in = b_ff; run_in = run_ff;
      if (req.start) begin
         acc_in = '0; a_in = req.a; b_in = req.b; run_in = 1'b1;
      end else if (run_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in = a_ff << 1;
         b_in = b_ff >> 1;
         if (b_ff[DivW-1:1] == '0) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) run_ff <= 1'b0;
      else       run_ff <= run_in;
      acc_ff <= acc_in; a_ff <= a_in; b_ff <= b_in;
   end

   // done depends on registers only, so a caller may restart in the done cycle
   assign done = run_ff && (b_ff[DivW-1:1] == '0);
   assign prod = b_ff[0] ? acc_ff + a_ff : acc_ff;
endmodule
`default_nettype wire

>>> sv/gbc_serial_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module gbc_serial_div import gbc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mul_req_type       req,
   output logic                   done,
   output logic [DivW-1:0]        quot
);
   localparam int CW = $clog2(DivW + 1);
   logic [DivW-1:0] q_ff, q_in, d_ff, d_in;
   logic [DivW:0]   r_ff, r_in, trial;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            fit;

   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; cnt_in = cnt_ff; run_in = run_ff;
      trial = {r_ff[DivW-1:0], q_ff[DivW-1]};
      fit = (trial >= {1'b0, d_ff});
      if (req.start) begin
         q_in = req.a; d_in = req.b; r_in = '0;
         cnt_in = CW'(DivW); run_in = 1'b1;
      end else if (run_ff) begin
         if (fit) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[DivW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) run_ff <= 1'b0;
      else       run_ff <= run_in;
      q_ff <= q_in; d_ff <= d_in; r_ff <= r_in; cnt_ff <= cnt_in;
   end

   // last quotient bit taken straight from the compare
   assign done = run_ff && (cnt_ff == CW'(1));
   assign quot = {q_ff[DivW-2:0], fit};
endmodule
`default_nettype wire

>>> sv/gyro_bias_calibrator.sv
// gyro bias calibrator: command 0 starts a run, command 1 is one sample
// attempt, command 2 loads offsets; every request yields exactly one
// response carrying status, offsets, warning and good count. one request
// is worked on at a time and the input is ready only in idle. a start, a
// load, an ignored command or a sample while idle goes from acceptance
// straight to the response state, a failed read through the accept
// check first; a good read squares each raw axis in the bit-serial
// multiplier before that check. the sample that ends a successful run
// then runs, per axis, four serial multiplies and two restoring
// divisions. a response the receiver has not taken holds the next
// request in the response state.
`default_nettype none
module gyro_bias_calibrator import gbc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // command[1:0], read_ok[2], raw_x[18:3], raw_y[34:19], raw_z[50:35],
   // preset_x[78:51], preset_y[106:79], preset_z[134:107], zero fill
   input  wire logic [135:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // busy_res[0], status[2:1], offset_x[30:3], offset_y[58:31],
   // offset_z[86:59], spread_warning[87], good_count[100:88], zero fill
   output logic [103:0]      rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [12:0]  csr_wdata
);
   localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_SQW = 4'd2,
      S_ACC = 4'd3, S_RESP = 4'd4, S_FIN = 4'd5, S_M1W = 4'd7,
      S_D1W = 4'd8, S_M2W = 4'd9, S_M3W = 4'd10, S_M4W = 4'd11,
      S_D2W = 4'd12, S_NEXT = 4'd13;

   logic [3:0]  st_ff, st_in;
   logic [1:0]  range_ff, range_in;
   logic [12:0] target_ff, target_in;
   logic        run_ff, run_in, warn_ff, warn_in, wacc_ff, wacc_in;
   logic signed [SumW-1:0] sum_ff [3];
   logic signed [SumW-1:0] sum_in [3];
   logic [SqW-1:0]  sq_ff [3];
   logic [SqW-1:0]  sq_in [3];
   logic signed [OffW-1:0] off_ff [3];
   logic signed [OffW-1:0] off_in [3];
   logic [CntW-1:0] good_ff, good_in, att_ff, att_in;
   logic [1:0]  ax_ff, ax_in, status_ff, status_in;
   logic [135:0] rq_ff, rq_in;
   logic [DivW-1:0] t_ff, t_in;
   logic        ov_ff, ov_in;
   logic [103:0] od_ff, od_in;
   mul_req_type mreq, dreq;
   logic        mdone, ddone;
   logic [DivW-1:0] mprod, dquot;

   gbc_serial_mul u_mul (.clock, .reset, .req(mreq), .done(mdone), .prod(mprod));
   gbc_serial_div u_div (.clock, .reset, .req(dreq), .done(ddone), .quot(dquot));

   logic [12:0] eff_t;
   logic signed [RawW-1:0] raw [3];
   logic signed [SumW-1:0] cur_sum;
   logic [SumW-1:0] mag;
   logic [DivW-1:0] den;
   logic [10:0] sc;

   always_comb begin
      eff_t = (target_ff > 13'(MaxSamples)) ? 13'(MaxSamples) : target_ff;
      for (int i = 0; i < 3; i++) raw[i] = rq_ff[3 + 16*i +: 16];
      cur_sum = sum_ff[ax_ff];
      mag = cur_sum[SumW-1] ? SumW'(-cur_sum) : cur_sum;
      sc  = scale_tenths(range_ff);
      den = DivW'({11'd0, good_ff} * {13'd0, sc}); // narrow: 13 x 11 bits
   end

   always_comb begin
      st_in = st_ff; range_in = range_ff; target_in = target_ff;
      run_in = run_ff; warn_in = warn_ff; wacc_in = wacc_ff;
      sum_in = sum_ff; sq_in = sq_ff; off_in = off_ff;
      good_in = good_ff; att_in = att_ff; ax_in = ax_ff;
      status_in = status_ff; rq_in = rq_ff;
      t_in = t_ff; ov_in = ov_ff; od_in = od_ff;
      mreq = '0; dreq = '0;
      if (csr_we) begin
         if (csr_index == CSR_RANGE) range_in = csr_wdata[1:0];
         else                        target_in = csr_wdata;
      end
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               rq_in = req_tdata; status_in = ST_OK; ax_in = 2'd0;
               st_in = S_RESP;
               case (req_tdata[1:0])
                  CMD_START: begin
                     if (run_ff) status_in = ST_BUSY;
                     else begin
                        for (int i = 0; i < 3; i++) begin
                           sum_in[i] = '0; sq_in[i] = '0;
                        end
                        good_in = '0; att_in = '0; run_in = 1'b1;
                        if (eff_t == '0) begin
                           run_in = 1'b0; status_in = ST_FAIL;
                        end
                     end
                  end
                  CMD_SAMPLE: begin
                     if (run_ff) begin
                        att_in = att_ff + 1'b1;
                        st_in = req_tdata[2] ? S_SQ : S_ACC;
                     end
                  end
                  CMD_LOAD: begin
                     if (run_ff) status_in = ST_BUSY;
                     else for (int i = 0; i < 3; i++)
                        off_in[i] = req_tdata[51 + 28*i +: 28];
                  end
                  default: ;
               endcase
            end
         end
         S_SQ: begin
            mreq.start = 1'b1;
            mreq.a = DivW'(raw[ax_ff][RawW-1] ? -32'(raw[ax_ff]) : 32'(raw[ax_ff]));
            mreq.b = mreq.a;
            st_in = S_SQW;
         end
         S_SQW: if (mdone) begin
            sum_in[ax_ff] = sum_ff[ax_ff] + SumW'(raw[ax_ff]);
            sq_in[ax_ff]  = sq_ff[ax_ff] + SqW'(mprod);
            if (ax_ff == 2'd2) begin
               ax_in = 2'd0; good_in = good_ff + 1'b1; st_in = S_ACC;
            end else begin
               ax_in = ax_ff + 1'b1; st_in = S_SQ;
            end
         end
         S_ACC: begin
            if (good_ff >= eff_t || 14'(att_ff) >= 14'(eff_t) + 14'(ExtraAttempts)) begin
               run_in = 1'b0;
               if (good_ff == '0 || good_ff < (eff_t >> 1)) begin
                  status_in = ST_FAIL; st_in = S_RESP;
               end else begin
                  status_in = ST_PASS; wacc_in = 1'b0; ax_in = 2'd0;
                  st_in = S_FIN;
               end
            end else st_in = S_RESP;
         end
         S_FIN: begin
            // dividend |sum| * 655360
            mreq.start = 1'b1; mreq.a = DivW'(mag); mreq.b = 64'd655360;
            st_in = S_M1W;
         end
         S_M1W: if (mdone) begin
            if (DivW'(mag) * 64'd10 > (den << 1)) wacc_in = 1'b1;
            dreq.start = 1'b1; dreq.a = mprod; dreq.b = den;
            st_in = S_D1W;
         end
         S_D1W: if (ddone) begin
            off_in[ax_ff] = cur_sum[SumW-1] ? OffW'(-dquot) : OffW'(dquot);
            mreq.start = 1'b1; mreq.a = DivW'(sq_ff[ax_ff]);
            mreq.b = DivW'(good_ff);
            st_in = S_M2W;
         end
         S_M2W: if (mdone) begin
            t_in = mprod;
            mreq.start = 1'b1; mreq.a = DivW'(mag); mreq.b = DivW'(mag);
            st_in = S_M3W;
         end
         S_M3W: if (mdone) begin
            t_in = t_ff - mprod;
            mreq.start = 1'b1; mreq.a = den; mreq.b = den;
            st_in = S_M4W;
         end
         S_M4W: if (mdone) begin
            dreq.start = 1'b1; dreq.a = mprod; dreq.b = 64'd100;
            st_in = S_D2W;
         end
         S_D2W: if (ddone) begin
            if (t_ff > dquot) wacc_in = 1'b1;
            st_in = S_NEXT;
         end
         S_NEXT: begin
            if (ax_ff == 2'd2) begin
               warn_in = wacc_ff; st_in = S_RESP;
            end else begin
               ax_in = ax_ff + 1'b1; st_in = S_FIN;
            end
         end
         S_RESP: if (!ov_ff || rsp_tready) begin
            ov_in = 1'b1;
            od_in = {3'd0, good_in, warn_in, off_in[2], off_in[1], off_in[0],
                     status_in, run_in};
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; range_ff <= 2'd1; target_ff <= 13'd1000;
         run_ff <= 1'b0; warn_ff <= 1'b0; ov_ff <= 1'b0;
         good_ff <= '0; att_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0; sq_ff[i] <= '0; off_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in; range_ff <= range_in; target_ff <= target_in;
         run_ff <= run_in; warn_ff <= warn_in; ov_ff <= ov_in;
         good_ff <= good_in; att_ff <= att_in;
         sum_ff <= sum_in; sq_ff <= sq_in; off_ff <= off_in;
      end
      wacc_ff <= wacc_in; ax_ff <= ax_in; status_ff <= status_in;
      rq_ff <= rq_in; t_ff <= t_in;
      od_ff <= od_in;
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

   ap_one_side: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !(st_ff != S_IDLE)) else $error("ready outside idle");
   ap_idle_pass: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_FIN) |-> !run_ff) else $error("finish while running");
   ap_good_cap: assert property (@(posedge clock) disable iff (reset)
      good_ff <= 13'(MaxSamples)) else $error("good count overflow");
endmodule
`default_nettype wire
